FILE: sv/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg
// Shared constants, types and helpers of the cross-cap surface evaluator.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int ANGLE_BITS_DEF    = 16;
  localparam int OUT_FRAC_BITS_DEF = 24;
  localparam int IN_ANGLE_W        = 16;
  localparam int CORDIC_STEPS      = 30;
  localparam int CW                = 33;  // cordic datapath width
  localparam int TRIG_W            = 32;  // Q2.30 signed
  localparam int OUT_W             = 40;
  localparam int ORD_W             = 2;

  localparam logic signed [CW-1:0] GAIN_START = 33'sh026DD3B6A;
  localparam logic signed [CW-1:0] TRIG_ONE   = 33'sh040000000;

  localparam logic [1:0] REG_RADIUS   = 2'd0;
  localparam logic [1:0] REG_U_ORDER  = 2'd1;
  localparam logic [1:0] REG_V_ORDER  = 2'd2;
  localparam logic [1:0] REG_EXPLICIT = 2'd3;

  typedef struct packed {
    logic [1:0] sh;
    logic       neg;
  } kfac_t;

  function automatic logic [31:0] atan_step(input int k);
    logic [31:0] r;
    case (k)
      0:  r = 32'h20000000;  1:  r = 32'h12E4051E;  2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;  4:  r = 32'h028B0D43;  5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;  7:  r = 32'h00517C55;  8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;  10: r = 32'h000A2F98;  11: r = 32'h000517CC;
      12: r = 32'h00028BE6;  13: r = 32'h000145F3;  14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;  16: r = 32'h000028BE;  17: r = 32'h0000145F;
      18: r = 32'h00000A30;  19: r = 32'h00000518;  20: r = 32'h0000028C;
      21: r = 32'h00000146;  22: r = 32'h000000A3;  23: r = 32'h00000051;
      24: r = 32'h00000029;  25: r = 32'h00000014;  26: r = 32'h0000000A;
      27: r = 32'h00000005;  28: r = 32'h00000003;  29: r = 32'h00000001;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // Q2.30 product, round half up
  function automatic logic signed [TRIG_W-1:0] qmul(input logic signed [TRIG_W-1:0] a,
                                                    input logic signed [TRIG_W-1:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + 64'sh20000000;
    return p[61:30];
  endfunction

  // derivative scale factors, all signed powers of two
  function automatic kfac_t k_x(input logic [1:0] i, input logic [1:0] j);
    kfac_t k;
    k.sh  = (i == 2'd2) ? 2'd2 : 2'd0;
    k.neg = (i == 2'd2) ^ (j == 2'd2);
    return k;
  endfunction

  function automatic kfac_t k_y(input logic [1:0] i, input logic [1:0] j);
    kfac_t k;
    k.sh  = ((i != 2'd0) ? 2'd1 : 2'd0) + ((j == 2'd2) ? 2'd2 : (j == 2'd1) ? 2'd1 : 2'd0);
    k.neg = (i != 2'd0) ^ (j == 2'd2);
    return k;
  endfunction

  function automatic kfac_t k_z(input logic [1:0] i, input logic [1:0] j);
    kfac_t k;
    k.sh  = ((i != 2'd0) ? 2'd1 : 2'd0) + ((j == 2'd2) ? 2'd2 : (j == 2'd1) ? 2'd1 : 2'd0);
    k.neg = (i != 2'd0) ^ (j != 2'd0);
    return k;
  endfunction

endpackage

FILE: sv/scc_cordic.sv
// ----------------------------------------------------------------------------
// scc_cordic
// Pipelined rotation CORDIC, one step per stage; clamped Q2.30 sin/cos out.
// ----------------------------------------------------------------------------
module scc_cordic import scc_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic [31:0]              phase,
  output logic signed [TRIG_W-1:0] cos_o,
  output logic signed [TRIG_W-1:0] sin_o
);

  logic signed [CW-1:0] x_r [0:CORDIC_STEPS];
  logic signed [CW-1:0] y_r [0:CORDIC_STEPS];
  logic signed [CW-1:0] z_r [0:CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      z_r[0] <= signed'({3'b000, phase[29:0]});
      case (phase[31:30])
        2'd0: begin x_r[0] <= GAIN_START;  y_r[0] <= '0;          end
        2'd1: begin x_r[0] <= '0;          y_r[0] <= GAIN_START;  end
        2'd2: begin x_r[0] <= -GAIN_START; y_r[0] <= '0;          end
        default: begin x_r[0] <= '0;       y_r[0] <= -GAIN_START; end
      endcase
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    localparam logic signed [CW-1:0] ATAN = signed'({1'b0, atan_step(k)});
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[k][CW-1]) begin
          x_r[k+1] <= x_r[k] - (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] + (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] - ATAN;
        end else begin
          x_r[k+1] <= x_r[k] + (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] - (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] + ATAN;
        end
      end
    end
  end

  logic signed [CW-1:0] xc, yc;
  always_comb begin
    xc = x_r[CORDIC_STEPS];
    yc = y_r[CORDIC_STEPS];
    if (xc > TRIG_ONE) xc = TRIG_ONE;
    if (xc < -TRIG_ONE) xc = -TRIG_ONE;
    if (yc > TRIG_ONE) yc = TRIG_ONE;
    if (yc < -TRIG_ONE) yc = -TRIG_ONE;
  end

  assign cos_o = xc[TRIG_W-1:0];
  assign sin_o = yc[TRIG_W-1:0];

endmodule

FILE: sv/cross_cap_surface_eval.sv
// Input beats pass CORDIC, clamp, product and difference stages to the
// sequencer, then product, radius-product and output registers. One result
// beat per cycle unless out_tready stalls, (du+1)*(dv+1) beats (1 to 9) per
// item; the trig pipeline takes an item per cycle unless the busy sequencer
// holds it. Reset (rst_n low, sync) clears all valid state, loads defaults.
// ----------------------------------------------------------------------------
// cross_cap_surface_eval
// Cross-cap surface point and partial derivatives, streaming in and out.
// ----------------------------------------------------------------------------
module cross_cap_surface_eval import scc_pkg::*; #(
  parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // u_angle[15:0], v_angle[31:16]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata,  // x_value[39:0], y_value[79:40], z_value[119:80]
  output logic [3:0]   out_tuser,  // u_order[1:0], v_order[3:2]
  output logic         out_tlast,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int SH = 54 - OUT_FRAC_BITS;
  localparam logic [31:0] AMASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);
  localparam logic signed [65:0] OMAX = 66'sd549755813887;
  localparam logic signed [65:0] OMIN = -66'sd549755813888;
  localparam logic signed [63:0] RHALF = 64'sd1 <<< (SH - 1);

  // configuration
  logic [15:0] radius_r;
  logic [1:0]  uord_r, vord_r;
  logic        expl_r;
  logic [31:0] r2_r;
  logic        wr;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 16'd4096;
      uord_r   <= 2'd0;
      vord_r   <= 2'd0;
      expl_r   <= 1'b1;
    end else if (wr) begin
      case (cfg_paddr[3:2])
        REG_RADIUS:   radius_r <= cfg_pwdata[15:0];
        REG_U_ORDER:  uord_r   <= cfg_pwdata[1:0];
        REG_V_ORDER:  vord_r   <= cfg_pwdata[1:0];
        REG_EXPLICIT: expl_r   <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    r2_r <= 32'(radius_r) * 32'(radius_r);
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_RADIUS:   cfg_prdata = {16'd0, radius_r};
      REG_U_ORDER:  cfg_prdata = {30'd0, uord_r};
      REG_V_ORDER:  cfg_prdata = {30'd0, vord_r};
      REG_EXPLICIT: cfg_prdata = {31'd0, expl_r};
      default:      cfg_prdata = '0;
    endcase
  end

  // stall control
  logic adv, e, emit, load, last_now;
  logic busy_r, dvld_r, ov_r;

  assign e         = !ov_r || out_tready;
  assign adv       = !dvld_r || (e && (!busy_r || last_now));
  assign in_tready = adv;

  // trig pipeline
  logic [31:0] pu, pv, p2v;
  assign pu  = ({16'd0, in_tdata[15:0]}  & AMASK) << (32 - ANGLE_BITS);
  assign pv  = ({16'd0, in_tdata[31:16]} & AMASK) << (32 - ANGLE_BITS);
  assign p2v = pv << 1;

  logic signed [TRIG_W-1:0] cu, su, cv, sv, c2v, s2v;

  scc_cordic u_cu  (.clk(clk), .en(adv), .phase(pu),  .cos_o(cu),  .sin_o(su));
  scc_cordic u_cv  (.clk(clk), .en(adv), .phase(pv),  .cos_o(cv),  .sin_o(sv));
  scc_cordic u_c2v (.clk(clk), .en(adv), .phase(p2v), .cos_o(c2v), .sin_o(s2v));

  logic cvld_r [0:CORDIC_STEPS];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= CORDIC_STEPS; k++) cvld_r[k] <= 1'b0;
    end else if (adv) begin
      cvld_r[0] <= in_tvalid;
      for (int k = 1; k <= CORDIC_STEPS; k++) cvld_r[k] <= cvld_r[k-1];
    end
  end

  // clamp register, products, difference
  logic signed [TRIG_W-1:0] kcu_r, ksu_r, kcv_r, ksv_r, kc2_r, ks2_r;
  logic signed [TRIG_W-1:0] ma_r, mc_r, ms_r, mcv_r, msv_r, mc2_r, ms2_r;
  logic signed [TRIG_W-1:0] da_r, dc_r, dd_r, dcv_r, dsv_r, dc2_r, ds2_r;
  logic kvld_r, mvld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kvld_r <= 1'b0;
      mvld_r <= 1'b0;
      dvld_r <= 1'b0;
    end else if (adv) begin
      kvld_r <= cvld_r[CORDIC_STEPS];
      mvld_r <= kvld_r;
      dvld_r <= mvld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kcu_r <= cu;  ksu_r <= su;  kcv_r <= cv;
      ksv_r <= sv;  kc2_r <= c2v; ks2_r <= s2v;
      ma_r  <= qmul(kcu_r, ksu_r);
      mc_r  <= qmul(kcu_r, kcu_r);
      ms_r  <= qmul(ksu_r, ksu_r);
      mcv_r <= kcv_r; msv_r <= ksv_r; mc2_r <= kc2_r; ms2_r <= ks2_r;
      da_r  <= ma_r;
      dc_r  <= mc_r;
      dd_r  <= mc_r - ms_r;
      dcv_r <= mcv_r; dsv_r <= msv_r; dc2_r <= mc2_r; ds2_r <= ms2_r;
    end
  end

  // result sequencer
  logic signed [TRIG_W-1:0] sa_r, sc_r, sd_r, scv_r, ssv_r, sc2_r, ss2_r;
  logic [1:0] i_r, j_r, du_r, dv_r;

  assign last_now = (i_r == du_r) && (j_r == dv_r);
  assign emit     = e && busy_r;
  assign load     = adv && dvld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (load) begin
      busy_r <= 1'b1;
    end else if (emit && last_now) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sa_r  <= da_r;  sc_r  <= dc_r;  sd_r  <= dd_r;
      scv_r <= dcv_r; ssv_r <= dsv_r; sc2_r <= dc2_r; ss2_r <= ds2_r;
      du_r  <= !expl_r ? 2'd0 : (uord_r == 2'd3) ? 2'd2 : uord_r;
      dv_r  <= !expl_r ? 2'd0 : (vord_r == 2'd3) ? 2'd2 : vord_r;
      i_r   <= 2'd0;
      j_r   <= 2'd0;
    end else if (emit && !last_now) begin
      if (j_r == dv_r) begin
        j_r <= 2'd0;
        i_r <= i_r + 2'd1;
      end else begin
        j_r <= j_r + 2'd1;
      end
    end
  end

  // operand select
  logic signed [TRIG_W-1:0] ux, uy, vx, vy, vz;
  always_comb begin
    case (i_r)
      2'd0:    begin ux = sa_r; uy = sc_r; end
      2'd1:    begin ux = sd_r; uy = sa_r; end
      default: begin ux = sa_r; uy = sd_r; end
    endcase
    case (j_r)
      2'd1:    begin vx = scv_r; vy = sc2_r; vz = ss2_r; end
      default: begin vx = ssv_r; vy = ss2_r; vz = sc2_r; end
    endcase
  end

  // result pipeline
  logic signed [TRIG_W-1:0] tx_r, ty_r, tz_r;
  logic [1:0] e1i_r, e1j_r, e2i_r, e2j_r;
  logic e1l_r, e2l_r, e1v_r, e2v_r;
  logic signed [63:0] px_r, py_r, pz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1v_r <= 1'b0;
      e2v_r <= 1'b0;
      ov_r  <= 1'b0;
    end else if (e) begin
      e1v_r <= emit;
      e2v_r <= e1v_r;
      ov_r  <= e2v_r;
    end
  end

  function automatic logic [OUT_W-1:0] scale(input logic signed [63:0] p, input kfac_t k);
    logic signed [63:0] rnd;
    logic signed [65:0] v;
    rnd = (p + RHALF) >>> SH;
    v = 66'(rnd) <<< k.sh;
    if (k.neg) v = -v;
    if (v > OMAX) v = OMAX;
    if (v < OMIN) v = OMIN;
    return v[OUT_W-1:0];
  endfunction

  logic signed [32:0] r2s;
  assign r2s = signed'({1'b0, r2_r});

  always_ff @(posedge clk) begin
    if (e) begin
      tx_r  <= qmul(ux, vx);
      ty_r  <= qmul(uy, vy);
      tz_r  <= qmul(uy, vz);
      e1i_r <= i_r;
      e1j_r <= j_r;
      e1l_r <= last_now;
      px_r  <= 64'(r2s * 65'(tx_r));
      py_r  <= 64'(r2s * 65'(ty_r));
      pz_r  <= 64'(r2s * 65'(tz_r));
      e2i_r <= e1i_r;
      e2j_r <= e1j_r;
      e2l_r <= e1l_r;
      out_tdata <= {scale(pz_r, k_z(e2i_r, e2j_r)),
                    scale(py_r, k_y(e2i_r, e2j_r)),
                    scale(px_r, k_x(e2i_r, e2j_r))};
      out_tuser <= {e2j_r, e2i_r};
      out_tlast <= e2l_r;
    end
  end

  assign out_tvalid = ov_r;

endmodule

FILE: sv/scc_checker.sv
// ----------------------------------------------------------------------------
// scc_checker
// Port-level checks of the cross-cap evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module scc_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [119:0] out_tdata,
  input logic [3:0]   out_tuser,
  input logic         out_tlast
);

  a_rst_idle: assert property (@(posedge clk) !$past(rst_n) |-> !out_tvalid)
    else $error("result beat right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
    && $stable(out_tlast))
    else $error("stalled result beat changed");

  a_ord: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[1:0] != 2'd3 && out_tuser[3:2] != 2'd3)
    else $error("derivative order out of range");

  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast ##1 out_tvalid |-> out_tuser == 4'd0)
    else $error("item does not start at position");

endmodule

bind cross_cap_surface_eval scc_checker u_scc_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
);

FILE: tb/sv/cross_cap_surface_eval_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cross_cap_surface_eval_tb
// Streams (u, v) angle pairs into the cross-cap evaluator and compares every
// result beat against a bit-exact CORDIC/fixed-point predictor, across
// radius, derivative-order and explicit-mode settings and idle/stall phases.
// ----------------------------------------------------------------------------
module cross_cap_surface_eval_tb;
  import scc_pkg::*;

  typedef struct packed {
    logic [39:0] x, y, z;
    logic [1:0]  uo, vo;
    logic        last;
  } surf_pt_t;

  logic         clk, rst_n;
  logic         in_tvalid, in_tready;
  logic [31:0]  in_tdata;
  logic         out_tvalid, out_tready;
  logic [119:0] out_tdata;
  logic [3:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [3:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata, cfg_prdata;

  cross_cap_surface_eval u_dut (.*);

  logic [31:0] angle_q[$];
  surf_pt_t    surf_q[$];
  int          n_err = 0;
  int          send_idle = 0, recv_stall = 0;
  logic [15:0] radius_r = 16'd4096;
  logic [1:0]  u_ord_r = 2'd0, v_ord_r = 2'd0;
  logic        expl_r = 1'b1;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic longint asr64(longint a, int s);
    return a >>> s;
  endfunction

  function automatic void cordic(logic [31:0] ph, output longint s, output longint c);
    longint x, y, z, dx, dy;
    x = 0; y = 0;
    z = longint'(ph[29:0]);
    case (ph[31:30])
      2'd0: x = 64'h26DD3B6A;
      2'd1: y = 64'h26DD3B6A;
      2'd2: x = -64'h26DD3B6A;
      default: y = -64'h26DD3B6A;
    endcase
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = asr64(y, i); dy = asr64(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_step(i));
      end else begin
        x += dx; y -= dy; z += longint'(atan_step(i));
      end
    end
    c = x > (64'sd1 <<< 30) ? (64'sd1 <<< 30) : x < -(64'sd1 <<< 30) ? -(64'sd1 <<< 30) : x;
    s = y > (64'sd1 <<< 30) ? (64'sd1 <<< 30) : y < -(64'sd1 <<< 30) ? -(64'sd1 <<< 30) : y;
  endfunction

  function automatic longint fxmul(longint a, longint b);
    return asr64(a * b + (64'sd1 <<< 29), 30);
  endfunction

  function automatic logic [39:0] scale_sat(longint r2, longint t, longint k);
    longint v;
    v = asr64(r2 * t + (64'sd1 <<< 29), 30) * k;
    if (v > (64'sd1 <<< 39) - 1) v = (64'sd1 <<< 39) - 1;
    if (v < -(64'sd1 <<< 39)) v = -(64'sd1 <<< 39);
    return v[39:0];
  endfunction

  task automatic predict_surface(logic [15:0] u, logic [15:0] v);
    longint su, cu, sv, cv, s2v, c2v, a, c2, d, r2;
    longint ux[3], uy[3], vx[3], vy[3], vz[3];
    longint kxu[3], kxv[3], kyu[3], kyv[3], kzv[3];
    int du, dv;
    surf_pt_t p;
    kxu = '{1, 1, -4}; kxv = '{1, 1, -1}; kyu = '{1, -2, -2};
    kyv = '{1, 2, -4}; kzv = '{1, -2, -4};
    cordic({u, 16'h0}, su, cu);
    cordic({v, 16'h0}, sv, cv);
    cordic({v[14:0], 17'h0}, s2v, c2v);
    a = fxmul(cu, su); c2 = fxmul(cu, cu); d = c2 - fxmul(su, su);
    r2 = longint'(radius_r) * longint'(radius_r);
    ux = '{a, d, a}; uy = '{c2, a, d};
    vx = '{sv, cv, sv}; vy = '{s2v, c2v, s2v}; vz = '{c2v, s2v, c2v};
    du = (u_ord_r == 2'd3) ? 2 : u_ord_r;
    dv = (v_ord_r == 2'd3) ? 2 : v_ord_r;
    if (!expl_r) begin
      du = 0; dv = 0;
    end
    for (int i = 0; i <= du; i++)
      for (int j = 0; j <= dv; j++) begin
        p.x = scale_sat(r2, fxmul(ux[i], vx[j]), kxu[i] * kxv[j]);
        p.y = scale_sat(r2, fxmul(uy[i], vy[j]), kyu[i] * kyv[j]);
        p.z = scale_sat(r2, fxmul(uy[i], vz[j]), kyu[i] * kzv[j]);
        p.uo = i[1:0]; p.vo = j[1:0];
        p.last = (i == du && j == dv);
        surf_q.push_back(p);
      end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) predict_surface(in_tdata[15:0], in_tdata[31:16]);
      if (angle_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        in_tvalid <= 1'b1;
        in_tdata  <= angle_q.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    surf_pt_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (surf_q.size() == 0) begin
          $error("unexpected result beat");
          n_err++;
        end else begin
          e = surf_q.pop_front();
          if (out_tdata[39:0] !== e.x) begin
            $error("x_value exp %h got %h", e.x, out_tdata[39:0]); n_err++;
          end
          if (out_tdata[79:40] !== e.y) begin
            $error("y_value exp %h got %h", e.y, out_tdata[79:40]); n_err++;
          end
          if (out_tdata[119:80] !== e.z) begin
            $error("z_value exp %h got %h", e.z, out_tdata[119:80]); n_err++;
          end
          if (out_tuser[1:0] !== e.uo) begin
            $error("u_order exp %0d got %0d", e.uo, out_tuser[1:0]); n_err++;
          end
          if (out_tuser[3:2] !== e.vo) begin
            $error("v_order exp %0d got %0d", e.vo, out_tuser[3:2]); n_err++;
          end
          if (out_tlast !== e.last) begin
            $error("last_result exp %0d got %0d", e.last, out_tlast); n_err++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_RADIUS:  radius_r = val[15:0];
      REG_U_ORDER: u_ord_r  = val[1:0];
      REG_V_ORDER: v_ord_r  = val[1:0];
      default:     expl_r   = val[0];
    endcase
  endtask

  task automatic drain;
    while (angle_q.size() > 0 || in_tvalid || surf_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_cfg(logic [31:0] r, logic [31:0] uo, logic [31:0] vo, logic [31:0] ex);
    reg_write(REG_RADIUS, r);
    reg_write(REG_U_ORDER, uo);
    reg_write(REG_V_ORDER, vo);
    reg_write(REG_EXPLICIT, ex);
  endtask

  task automatic push_random(int n);
    logic [15:0] u, v;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(3))
        0: u = 16'({$urandom_range(3), 14'h0} + $urandom_range(3) - 2);
        default: u = 16'($urandom);
      endcase
      v = ($urandom_range(4) == 0) ? 16'({$urandom_range(7), 13'h0}) : 16'($urandom);
      angle_q.push_back({v, u});
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = 0; cfg_pwdata = 0;
    in_tvalid = 0; in_tdata = 0; out_tready = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // defaults first: radius 1.0, position only
    angle_q.push_back({16'h0000, 16'h0000});
    angle_q.push_back({16'hFFFF, 16'hFFFF});
    angle_q.push_back({16'h4000, 16'h2000});
    drain();
    set_cfg(32'hFFFF_FFFF, 32'd2, 32'd2, 32'd1);
    angle_q.push_back({16'h0000, 16'h0000});
    angle_q.push_back({16'hFFFF, 16'hFFFF});
    angle_q.push_back({16'h2000, 16'h1000});
    angle_q.push_back({16'h8000, 16'hC000});
    angle_q.push_back({16'h5555, 16'hAAAA});
    drain();
    set_cfg(32'h0, 32'd3, 32'd3, 32'd1);
    angle_q.push_back({16'h1234, 16'h5678});
    angle_q.push_back({16'hAAAA, 16'h5555});
    drain();
    set_cfg(32'h0001_2000, 32'd2, 32'd1, 32'd0);
    angle_q.push_back({16'h1000, 16'h0800});
    angle_q.push_back({16'hF000, 16'h7FFF});
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      set_cfg($urandom, $urandom_range(3), $urandom_range(3), 32'($urandom_range(7) != 0));
      if (ph == 3) reg_write(REG_RADIUS, 32'hFFFF);
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 49; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 49; end
        default: begin send_idle = 30; recv_stall = 30; end
      endcase
      push_random(50);
      drain();
    end
    if (n_err == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
